@@ hdl/pointer_interning_handle_table_macros.svh @@
// Assertion macros for the handle table checker.
`ifndef POINTER_INTERNING_HANDLE_TABLE_MACROS_SVH
`define POINTER_INTERNING_HANDLE_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PITH_ASSERT_NOW(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("handle table check failed");

// Next-cycle implication, disabled in reset.
`define PITH_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("handle table check failed");

`endif

@@ hdl/pith_pkg.sv @@
// ----------------------------------------------------------------------------
// pith_pkg
// Types, sizes and codes shared by the pointer interning handle table.
// ----------------------------------------------------------------------------
package pith_pkg;

  localparam int CAPACITY  = 4096;
  localparam int BUCKETS   = 2048;
  localparam int H_W       = 13;
  localparam int KEY_W     = 64;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CMP_W     = (CNT_W > H_W) ? CNT_W : H_W;
  localparam int MIX_SHIFT = 33;
  localparam logic [KEY_W-1:0] MIX_MUL = 64'hff51afd7ed558ccd;
  localparam logic [BKT_W-1:0] BKT_MASK = BKT_W'(BUCKETS - 1);
  localparam int QDEPTH    = 4;
  localparam int QP_W      = $clog2(QDEPTH);

  localparam logic REQ_INTERN = 1'b0;
  localparam logic REQ_GET    = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NEW   = 2'd1,
    ST_NONE  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_GET    = 2'd0,
    K_NULL   = 2'd1,
    K_INTERN = 2'd2
  } kind_t;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [H_W-1:0]   handle_in;
  } in_item_t;

  typedef struct packed {
    logic [H_W-1:0]   handle_out;
    logic [KEY_W-1:0] key_out;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
    logic [H_W-1:0]   handle_in;
    logic [BKT_W-1:0] bucket;
  } work_t;

endpackage

@@ hdl/pith_front.sv @@
// ----------------------------------------------------------------------------
// pith_front
// Accepts requests, classifies them and hashes intern keys to a bucket.
// ----------------------------------------------------------------------------
module pith_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              block,
  input  logic              in_valid,
  output logic              in_stall,
  input  pith_pkg::in_item_t in_item,
  output logic              q_valid,
  input  logic              q_stall,
  output pith_pkg::work_t   q_item
);
  import pith_pkg::*;

  logic             va, vb, vc;
  in_item_t         ia, ib, ic;
  logic [KEY_W-1:0] u;
  logic [KEY_W-1:0] p0;
  logic [31:0]      p1, p2;
  logic [KEY_W-1:0] m;
  logic [KEY_W-1:0] v2;
  logic             adv, acc;

  assign adv      = !(vc && q_stall);
  assign in_stall = block || !adv;
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (adv) begin
      va <= acc;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ia <= in_item;
      u  <= in_item.key ^ (in_item.key >> MIX_SHIFT);
      ib <= ia;
      p0 <= {32'b0, u[31:0]} * {32'b0, MIX_MUL[31:0]};
      p1 <= 32'(u[63:32] * MIX_MUL[31:0]);
      p2 <= 32'(u[31:0] * MIX_MUL[63:32]);
      ic <= ib;
      m  <= p0 + {32'(p1 + p2), 32'b0};
    end
  end

  assign v2 = m ^ (m >> MIX_SHIFT);

  always_comb begin
    q_valid          = vc;
    q_item.key       = ic.key;
    q_item.handle_in = ic.handle_in;
    q_item.bucket    = v2[BKT_W-1:0] & BKT_MASK;
    if (ic.req_type == REQ_GET) begin
      q_item.kind = K_GET;
    end else if (ic.key == '0) begin
      q_item.kind = K_NULL;
    end else begin
      q_item.kind = K_INTERN;
    end
  end

endmodule

@@ hdl/pith_queue.sv @@
// ----------------------------------------------------------------------------
// pith_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module pith_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_stall,
  input  pith_pkg::work_t push_item,
  output logic            pop_valid,
  input  logic            pop_stall,
  output pith_pkg::work_t pop_item
);
  import pith_pkg::*;

  work_t           slots [QDEPTH];
  logic [QP_W-1:0] wp, rp;
  logic [QP_W:0]   cnt;
  logic            push, pop;

  assign push_stall = (cnt == (QP_W+1)'(QDEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_item   = slots[rp];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (QP_W+1)'(push) - (QP_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_item;
  end

endmodule

@@ hdl/pith_back.sv @@
// ----------------------------------------------------------------------------
// pith_back
// Walks bucket chains, allocates handles and answers get requests.
// ----------------------------------------------------------------------------
module pith_back (
  input  logic               clk,
  input  logic               rst,
  output logic               clearing,
  input  logic               q_valid,
  output logic               q_stall,
  input  pith_pkg::work_t    q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pith_pkg::out_item_t out_item
);
  import pith_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_GET   = 6'b000100,
    S_HEAD  = 6'b001000,
    S_TEST  = 6'b010000,
    S_CMP   = 6'b100000
  } state_t;

  state_t           state;
  work_t            w;
  logic [BKT_W-1:0] clr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] steps;
  logic [H_W-1:0]   cur, head;

  logic [H_W-1:0]   heads [BUCKETS];
  logic [KEY_W-1:0] keys  [CAPACITY];
  logic [H_W-1:0]   links [CAPACITY];
  logic [H_W-1:0]   head_rd, link_rd;
  logic [KEY_W-1:0] key_rd;

  logic             pop, walk_ok, full, get_ok;
  logic             head_we, ent_we;
  logic [BKT_W-1:0] head_waddr;
  logic [H_W-1:0]   head_wdata;
  logic [IDX_W-1:0] ent_raddr;
  logic [CMP_W-1:0] cur_x, hin_x, cnt_x;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && q_valid && !out_valid;
  assign q_stall  = !pop;
  assign cur_x    = CMP_W'(cur);
  assign hin_x    = CMP_W'(q_item.handle_in);
  assign cnt_x    = CMP_W'(count);
  assign get_ok   = (hin_x != '0) && (hin_x <= cnt_x);
  assign walk_ok  = (cur_x != '0) && (cur_x <= cnt_x) && (steps < CNT_W'(CAPACITY));
  assign full     = (count >= CNT_W'(CAPACITY));

  always_comb begin
    ent_raddr  = (state == S_IDLE) ? IDX_W'(hin_x - 1'b1) : IDX_W'(cur_x - 1'b1);
    ent_we     = (state == S_TEST) && !walk_ok && !full;
    head_we    = clearing || ent_we;
    head_waddr = clearing ? clr : w.bucket;
    head_wdata = clearing ? '0 : H_W'(count + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (head_we) heads[head_waddr] <= head_wdata;
    head_rd <= heads[q_item.bucket];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      keys[count[IDX_W-1:0]]  <= w.key;
      links[count[IDX_W-1:0]] <= head;
    end
    key_rd  <= keys[ent_raddr];
    link_rd <= links[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == BKT_W'(BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            w <= q_item;
            unique case (q_item.kind)
              K_GET: begin
                if (get_ok) begin
                  state <= S_GET;
                end else begin
                  out_valid <= 1'b1;
                  out_item  <= '{handle_out: '0, key_out: '0, status: ST_NONE};
                end
              end
              K_INTERN: state <= S_HEAD;
              default: begin
                out_valid <= 1'b1;
                out_item  <= '{handle_out: '0, key_out: '0, status: ST_NONE};
              end
            endcase
          end
        end
        S_GET: begin
          out_valid <= 1'b1;
          out_item  <= '{handle_out: w.handle_in, key_out: key_rd, status: ST_FOUND};
          state     <= S_IDLE;
        end
        S_HEAD: begin
          cur   <= head_rd;
          head  <= head_rd;
          steps <= '0;
          state <= S_TEST;
        end
        S_TEST: begin
          if (walk_ok) begin
            state <= S_CMP;
          end else begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (full) begin
              out_item <= '{handle_out: '0, key_out: '0, status: ST_FULL};
            end else begin
              count    <= count + 1'b1;
              out_item <= '{handle_out: H_W'(count + 1'b1), key_out: w.key, status: ST_NEW};
            end
          end
        end
        S_CMP: begin
          if (key_rd == w.key) begin
            out_valid <= 1'b1;
            out_item  <= '{handle_out: cur, key_out: w.key, status: ST_FOUND};
            state     <= S_IDLE;
          end else begin
            cur   <= link_rd;
            steps <= steps + 1'b1;
            state <= S_TEST;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/pointer_interning_handle_table.sv @@
// ----------------------------------------------------------------------------
// pointer_interning_handle_table
// Gives each distinct nonzero 64-bit key a dense handle and returns keys.
//
//   channel  signals                     direction
//   in       in_valid in_stall in_item   request into the block
//   out      out_valid out_stall out_item result out of the block
//
// Back end: a null key or unissued get is answered from the idle state, an
// issued get reads the entry memory, and an intern reads the bucket head and
// walks the chain, reading the single-port entry memory per entry visited.
// Front hashing is pipelined; a 4-entry queue decouples.
// After reset the bucket heads are cleared while in_stall is high.
// out_stall holds the result register; in_stall rises when the queue fills.
// ----------------------------------------------------------------------------
module pointer_interning_handle_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pith_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pith_pkg::out_item_t out_item
);
  import pith_pkg::*;

  logic  clearing;
  logic  f_valid, f_stall, b_valid, b_stall;
  work_t f_item, b_item;

  pith_front u_front (
    .clk, .rst,
    .block    (clearing),
    .in_valid,
    .in_stall,
    .in_item,
    .q_valid  (f_valid),
    .q_stall  (f_stall),
    .q_item   (f_item)
  );

  pith_queue u_queue (
    .clk, .rst,
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_stall  (b_stall),
    .pop_item   (b_item)
  );

  pith_back u_back (
    .clk, .rst,
    .clearing,
    .q_valid  (b_valid),
    .q_stall  (b_stall),
    .q_item   (b_item),
    .out_valid,
    .out_stall,
    .out_item
  );

endmodule

@@ hdl/pith_checker.sv @@
// ----------------------------------------------------------------------------
// pith_checker
// Port-level checks on the handle table results.
// ----------------------------------------------------------------------------
`include "pointer_interning_handle_table_macros.svh"

module pith_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input pith_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input pith_pkg::out_item_t out_item
);
  import pith_pkg::*;

  `PITH_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item))
  `PITH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `PITH_ASSERT_NOW(a_new_nonzero, out_valid && out_item.status == ST_NEW,
                   out_item.handle_out != '0 && out_item.key_out != '0)
  `PITH_ASSERT_NOW(a_none_zero, out_valid && (out_item.status == ST_NONE ||
                   out_item.status == ST_FULL),
                   out_item.handle_out == '0 && out_item.key_out == '0)
  `PITH_ASSERT_NOW(a_found_nonzero, out_valid && out_item.status == ST_FOUND,
                   out_item.handle_out != '0)

endmodule

bind pointer_interning_handle_table pith_checker u_pith_checker (
  .clk, .rst, .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item
);
